FILE: sv/circq_pkg.sv
// Shared types and codes for the circular queue core.
`timescale 1ns / 1ps
`default_nettype none

package circq_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic [1:0] cq_cmd_t;
    typedef logic [1:0] cq_status_t;

    localparam cq_cmd_t CMD_INSERT  = 2'd0;
    localparam cq_cmd_t CMD_DELETE  = 2'd1;
    localparam cq_cmd_t CMD_DISPLAY = 2'd2;
    localparam cq_cmd_t CMD_IGNORED = 2'd3;

    localparam cq_status_t STATUS_OK        = 2'd0;
    localparam cq_status_t STATUS_OVERFLOW  = 2'd1;
    localparam cq_status_t STATUS_UNDERFLOW = 2'd2;
    localparam cq_status_t STATUS_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEL,
        ST_DISP
    } cq_state_t;

endpackage : circq_pkg

`default_nettype wire

FILE: sv/circular_queue_core.sv
// Insert, delete and display results are held in an output register taken by out_valid/out_stall.
// Insert, overflow, underflow and empty-display results appear in the cycle after the item is taken.
// A delete reads the head slot into rd_data_reg and enters ST_DEL, which registers its result.
// A display enters ST_DISP, which registers one entry per cycle from the head while not stalled.
// A new item is taken only in ST_IDLE, so a delete or display stalls the input until it is done.
// Reset clears the indices, the empty flag and the control state; the slot memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module circular_queue_core
    import circq_pkg::*;
#(
    parameter int unsigned DEPTH = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [1:0]               cmd,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      data,
    output logic                          last
);

    localparam int unsigned AW = $clog2(DEPTH);

    cq_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic empty_reg, empty_next;

    logic out_valid_reg, out_valid_next;
    cq_status_t status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic last_reg, last_next;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic wr_en;

    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] idx_inc;
    logic out_free;
    logic in_acc;
    logic full;

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign idx_inc  = (idx_reg == AW'(DEPTH - 1)) ? '0 : idx_reg + 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_acc   = in_valid && !in_stall;
    assign full     = !empty_reg && (tail_inc == head_reg);

    assign rd_addr = (state_reg == ST_DISP) ? idx_next : head_reg;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_inc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (cmd)
                        CMD_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            last_next      = 1'b1;
                            data_next      = '0;
                            status_next    = STATUS_OK;
                            if (empty_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                            end
                            else if (full)
                            begin
                                status_next = STATUS_OVERFLOW;
                            end
                            else
                            begin
                                tail_next = tail_inc;
                                wr_en     = 1'b1;
                                wr_addr   = tail_inc;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (empty_reg)
                            begin
                                out_valid_next = 1'b1;
                                last_next      = 1'b1;
                                data_next      = '0;
                                status_next    = STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                state_next = ST_DEL;
                            end
                        end
                        CMD_DISPLAY:
                        begin
                            if (empty_reg)
                            begin
                                out_valid_next = 1'b1;
                                last_next      = 1'b1;
                                data_next      = '0;
                                status_next    = STATUS_EMPTY;
                            end
                            else
                            begin
                                idx_next   = head_reg;
                                state_next = ST_DISP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DEL:
            begin
                out_valid_next = 1'b1;
                last_next      = 1'b1;
                status_next    = STATUS_OK;
                data_next      = rd_data_reg;
                state_next     = ST_IDLE;
                if (head_reg == tail_reg)
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end
                else
                begin
                    head_next = head_inc;
                end
            end
            ST_DISP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STATUS_OK;
                    data_next      = rd_data_reg;
                    last_next      = (idx_reg == tail_reg);
                    if (idx_reg == tail_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            idx_reg       <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            idx_reg       <= idx_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("Empty queue with non-zero indices.");

    a_overflow_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (cmd == CMD_INSERT) && full) |=>
            $stable(head_reg) && $stable(tail_reg) && !empty_reg)
        else $error("Overflowing insert changed the queue.");

    a_delete_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (cmd == CMD_DELETE) && !empty_reg) |=>
            (state_reg == ST_DEL) && !out_valid_reg)
        else $error("Delete did not enter its read cycle with a free output.");

    a_display_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DISP) && out_free && (idx_reg == tail_reg)) |=>
            (state_reg == ST_IDLE) && out_valid_reg && last_reg)
        else $error("Display walk did not finish on the newest entry.");

endmodule : circular_queue_core

`default_nettype wire
